[rtl/core/cwl_pkg.sv]
// ----------------------------------------------------------------------------
// cwl_pkg
// Shared types, constants and tables of the competitive winner-learn layer.
// ----------------------------------------------------------------------------
package cwl_pkg;

   // Layer dimensions.
   localparam int NEURONS     = 16;
   localparam int INPUTS      = 16;
   localparam int OUTPUTS     = 8;
   localparam int VALUE_BITS  = 16;

   localparam int NEURON_BITS = $clog2(NEURONS);
   localparam int INPUT_BITS  = $clog2(INPUTS);
   localparam int OUTPUT_BITS = $clog2(OUTPUTS);
   localparam int COUNT_BITS  = $clog2(INPUTS + 1);

   localparam int WEIGHT_DEPTH = NEURONS * INPUTS;
   localparam int LEARN_DEPTH  = NEURONS * OUTPUTS;
   localparam int WADDR_BITS   = $clog2(WEIGHT_DEPTH);
   localparam int LADDR_BITS   = $clog2(LEARN_DEPTH);

   // Distance arithmetic.
   localparam int DIST_BITS  = 17;
   localparam int CLOSE_BITS = 16;
   localparam int KEEP_BITS  = 16;
   localparam int SUM_BITS   = VALUE_BITS + COUNT_BITS;
   localparam int QUOT_BITS  = SUM_BITS + 1;
   localparam logic [DIST_BITS-1:0] ONE_Q16 = 17'd65536;

   // Register reset values and indexes.
   localparam logic [KEEP_BITS-1:0]  KEEP_RESET   = 16'd58982;
   localparam logic [COUNT_BITS-1:0] INUSE_RESET  = COUNT_BITS'(INPUTS);
   localparam logic CSR_KEEP_FACTOR   = 1'b0;
   localparam logic CSR_INPUTS_IN_USE = 1'b1;

   // Action codes.
   localparam logic [2:0] ACT_SAMPLE = 3'd0;
   localparam logic [2:0] ACT_LEARN  = 3'd1;
   localparam logic [2:0] ACT_BLEND  = 3'd2;
   localparam logic [2:0] ACT_READ   = 3'd3;
   localparam logic [2:0] ACT_LOAD   = 3'd4;

   // Result kinds.
   localparam logic KIND_DISTANCE = 1'b0;
   localparam logic KIND_READ     = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCORE,
      ST_EMIT,
      ST_LEARN_RD,
      ST_LEARN_MUL,
      ST_LEARN_WR,
      ST_BLEND_MUL,
      ST_BLEND_WR,
      ST_READ_EMIT
   } top_state_type;

   typedef enum logic [1:0] {
      SC_IDLE,
      SC_DIV,
      SC_EXP,
      SC_DONE
   } score_state_type;

   // Status of the scoring unit towards the sequencer.
   typedef struct packed {
      logic                  done;
      logic [DIST_BITS-1:0]  distance;
      logic [CLOSE_BITS-1:0] closeness;
   } score_type;

   // Factors of 100^-(2^(b-16)) in Q30, one per distance bit.
   typedef logic [DIST_BITS-1:0][30:0] close_fac_type;

   function automatic close_fac_type close_factors();
      close_fac_type f;
      logic [63:0]   r;
      logic [63:0]   v;
      logic [63:0]   res;
      logic [63:0]   bit_v;
      r = 64'd10737418;
      for (int b = DIST_BITS - 1; b >= 0; b--) begin
         f[b] = r[30:0];
         v    = r << 30;
         res  = 64'd0;
         for (int k = 31; k >= 0; k--) begin
            bit_v = 64'd1 << (2 * k);
            if (v >= res + bit_v) begin
               v   = v - (res + bit_v);
               res = (res >> 1) + bit_v;
            end else begin
               res = res >> 1;
            end
         end
         r = res;
      end
      return f;
   endfunction

   localparam close_fac_type CLOSE_FACTORS = close_factors();

endpackage

[rtl/core/competitive_layer_winner_learn_top.sv]
// ----------------------------------------------------------------------------
// competitive_layer_winner_learn_top
// Winner-take-all layer: weight and learned-output memories, a sequencer that
// scores every neuron, and winner learning by read-modify-write.
// ----------------------------------------------------------------------------
// The last element of a sample starts a scan of every neuron in turn: the
// weight scan reads one word a cycle, then the divider and the power walk score
// the neuron, and one result per neuron is emitted. Learn, blend, read and the
// other actions run on their own; the block takes one item at a time.
// Reset is synchronous; learned outputs read as zero until written, the
// weight memory is not cleared.
module competitive_layer_winner_learn_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [2:0]                            req_action,
   input  logic signed [cwl_pkg::VALUE_BITS-1:0] req_element_value,
   input  logic [cwl_pkg::NEURON_BITS-1:0]       req_neuron_select,
   input  logic [cwl_pkg::INPUT_BITS-1:0]        req_element_index,
   input  logic [cwl_pkg::OUTPUT_BITS-1:0]       req_output_index,
   input  logic signed [cwl_pkg::VALUE_BITS-1:0] req_target_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_result_kind,
   output logic [cwl_pkg::NEURON_BITS-1:0]       rsp_neuron_index,
   output logic [cwl_pkg::DIST_BITS-1:0]         rsp_distance,
   output logic [cwl_pkg::CLOSE_BITS-1:0]        rsp_closeness,
   output logic [cwl_pkg::NEURON_BITS-1:0]       rsp_winner_index,
   output logic [cwl_pkg::DIST_BITS-1:0]         rsp_winner_distance,
   output logic                                  rsp_last_result,
   output logic signed [cwl_pkg::VALUE_BITS-1:0] rsp_read_value,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic                                  csr_index,
   input  logic [cwl_pkg::KEEP_BITS-1:0]         csr_data
);
   import cwl_pkg::*;

   top_state_type                state_ff;
   top_state_type                state_in;

   logic [KEEP_BITS-1:0]         keep_ff;
   logic [COUNT_BITS-1:0]        inuse_ff;
   logic [COUNT_BITS-1:0]        n_cur;

   logic signed [VALUE_BITS-1:0] vec_ff [INPUTS];
   logic [COUNT_BITS-1:0]        counter_ff;
   logic [COUNT_BITS-1:0]        counter_in;
   logic [COUNT_BITS-1:0]        slot;
   logic [COUNT_BITS-1:0]        slot_next;
   logic                         vec_we;

   logic [NEURON_BITS-1:0]       winner_ff;
   logic [NEURON_BITS-1:0]       winner_in;
   logic [DIST_BITS-1:0]         best_ff;
   logic [DIST_BITS-1:0]         best_in;

   logic [NEURON_BITS-1:0]       nrn_ff;
   logic [NEURON_BITS-1:0]       nrn_in;
   logic [COUNT_BITS-1:0]        idx_ff;
   logic [COUNT_BITS-1:0]        idx_in;
   logic                         pend_ff;
   logic                         pend_in;
   logic [INPUT_BITS-1:0]        pidx_ff;
   logic [INPUT_BITS-1:0]        pidx_in;
   logic [SUM_BITS-1:0]          sum_ff;
   logic [SUM_BITS-1:0]          sum_in;

   logic [LADDR_BITS-1:0]        lo_addr_ff;
   logic [LADDR_BITS-1:0]        lo_addr_in;
   logic signed [VALUE_BITS-1:0] tgt_ff;
   logic signed [VALUE_BITS-1:0] tgt_in;
   logic [LEARN_DEPTH-1:0]       lo_valid_ff;

   logic                         accept;
   logic                         out_free;
   logic                         idx_done;
   logic                         score_start;
   logic                         better;
   score_type                    score;

   logic                         w_we;
   logic [WADDR_BITS-1:0]        w_waddr;
   logic [VALUE_BITS-1:0]        w_wdata;
   logic [WADDR_BITS-1:0]        w_raddr;
   logic [VALUE_BITS-1:0]        w_rdata;
   logic                         lo_we;
   logic [LADDR_BITS-1:0]        lo_raddr;
   logic [VALUE_BITS-1:0]        lo_rdata;

   logic signed [VALUE_BITS-1:0] bl_old;
   logic signed [VALUE_BITS-1:0] bl_tgt;
   logic signed [VALUE_BITS-1:0] bl_result;
   logic signed [VALUE_BITS:0]   diff;
   logic [VALUE_BITS:0]          abs_diff;

   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic                         rsp_load_dist;
   logic                         rsp_load_read;
   logic                         rsp_kind_ff;
   logic [NEURON_BITS-1:0]       rsp_nrn_ff;
   logic [DIST_BITS-1:0]         rsp_dist_ff;
   logic [CLOSE_BITS-1:0]        rsp_close_ff;
   logic [NEURON_BITS-1:0]       rsp_win_ff;
   logic [DIST_BITS-1:0]         rsp_wdist_ff;
   logic                         rsp_last_ff;
   logic signed [VALUE_BITS-1:0] rsp_read_ff;

   // Memories.
   cwl_ram #(.WIDTH(VALUE_BITS), .DEPTH(WEIGHT_DEPTH)) u_weight_ram (
      .clock   (clock),
      .wr_en   (w_we),
      .wr_addr (w_waddr),
      .wr_data (w_wdata),
      .rd_addr (w_raddr),
      .rd_data (w_rdata)
   );

   cwl_ram #(.WIDTH(VALUE_BITS), .DEPTH(LEARN_DEPTH)) u_learn_ram (
      .clock   (clock),
      .wr_en   (lo_we),
      .wr_addr (lo_addr_ff),
      .wr_data (bl_result),
      .rd_addr (lo_raddr),
      .rd_data (lo_rdata)
   );

   cwl_blend u_blend (
      .clock     (clock),
      .keep      (keep_ff),
      .old_value (bl_old),
      .target    (bl_tgt),
      .result    (bl_result)
   );

   cwl_score u_score (
      .clock  (clock),
      .reset  (reset),
      .start  (score_start),
      .sum    (sum_ff),
      .count  (n_cur),
      .result (score)
   );

   // Handshakes and shared conditions.
   assign csr_ready   = 1'b1;
   assign req_stall   = (state_ff != ST_IDLE);
   assign accept      = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign idx_done    = (idx_ff == n_cur);
   assign score_start = (state_ff == ST_SCAN) && idx_done && !pend_ff;
   assign better      = (nrn_ff == '0) || (score.distance < best_ff);

   // Element count in use, clamped to between one and the vector length.
   always_comb begin
      if (inuse_ff == '0) begin
         n_cur = COUNT_BITS'(1);
      end else if (inuse_ff > COUNT_BITS'(INPUTS)) begin
         n_cur = COUNT_BITS'(INPUTS);
      end else begin
         n_cur = inuse_ff;
      end
   end

   // Sample slot; a lowered count restarts the fill.
   assign slot      = (counter_ff >= n_cur) ? '0 : counter_ff;
   assign slot_next = slot + COUNT_BITS'(1);

   // Absolute difference of a weight and its input element.
   assign diff     = $signed({w_rdata[VALUE_BITS-1], w_rdata})
                     - $signed({vec_ff[pidx_ff][VALUE_BITS-1], vec_ff[pidx_ff]});
   assign abs_diff = diff[VALUE_BITS] ? (VALUE_BITS + 1)'(-diff) : diff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_SAMPLE: begin
                     if (slot_next == n_cur) begin
                        state_in = ST_SCAN;
                     end
                  end
                  ACT_LEARN: state_in = ST_LEARN_RD;
                  ACT_BLEND: state_in = ST_BLEND_MUL;
                  ACT_READ:  state_in = ST_READ_EMIT;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            if (score_start) begin
               state_in = ST_SCORE;
            end
         end
         ST_SCORE: begin
            if (score.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = (nrn_ff == NEURON_BITS'(NEURONS - 1)) ? ST_IDLE : ST_SCAN;
            end
         end
         ST_LEARN_RD:  state_in = ST_LEARN_MUL;
         ST_LEARN_MUL: state_in = ST_LEARN_WR;
         ST_LEARN_WR: begin
            state_in = (idx_ff + COUNT_BITS'(1) == n_cur) ? ST_IDLE : ST_LEARN_RD;
         end
         ST_BLEND_MUL: state_in = ST_BLEND_WR;
         ST_BLEND_WR:  state_in = ST_IDLE;
         ST_READ_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      counter_in    = counter_ff;
      vec_we        = 1'b0;
      winner_in     = winner_ff;
      best_in       = best_ff;
      nrn_in        = nrn_ff;
      idx_in        = idx_ff;
      pend_in       = 1'b0;
      pidx_in       = pidx_ff;
      sum_in        = sum_ff;
      lo_addr_in    = lo_addr_ff;
      tgt_in        = tgt_ff;
      w_we          = 1'b0;
      w_waddr       = {req_neuron_select, req_element_index};
      w_wdata       = req_element_value;
      w_raddr       = {nrn_ff, idx_ff[INPUT_BITS-1:0]};
      lo_we         = 1'b0;
      lo_raddr      = lo_addr_ff;
      bl_old        = w_rdata;
      bl_tgt        = vec_ff[idx_ff[INPUT_BITS-1:0]];
      rsp_load_dist = 1'b0;
      rsp_load_read = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            lo_raddr = {winner_ff, req_output_index};
            if (accept) begin
               lo_addr_in = {winner_ff, req_output_index};
               tgt_in     = req_target_value;
               idx_in     = '0;
               case (req_action)
                  ACT_SAMPLE: begin
                     vec_we = 1'b1;
                     if (slot_next == n_cur) begin
                        counter_in = '0;
                        nrn_in     = '0;
                        sum_in     = '0;
                     end else begin
                        counter_in = slot_next;
                     end
                  end
                  ACT_LOAD: w_we = 1'b1;
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (!idx_done) begin
               pend_in = 1'b1;
               pidx_in = idx_ff[INPUT_BITS-1:0];
               idx_in  = idx_ff + COUNT_BITS'(1);
            end
            if (pend_ff) begin
               sum_in = sum_ff + SUM_BITS'(abs_diff);
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_load_dist = 1'b1;
               if (better) begin
                  winner_in = nrn_ff;
                  best_in   = score.distance;
               end
               nrn_in = nrn_ff + NEURON_BITS'(1);
               idx_in = '0;
               sum_in = '0;
            end
         end
         ST_LEARN_RD: begin
            w_raddr = {winner_ff, idx_ff[INPUT_BITS-1:0]};
         end
         ST_LEARN_WR: begin
            w_we    = 1'b1;
            w_waddr = {winner_ff, idx_ff[INPUT_BITS-1:0]};
            w_wdata = bl_result;
            idx_in  = idx_ff + COUNT_BITS'(1);
         end
         ST_BLEND_MUL: begin
            bl_old = lo_valid_ff[lo_addr_ff] ? lo_rdata : '0;
            bl_tgt = tgt_ff;
         end
         ST_BLEND_WR: begin
            lo_we = 1'b1;
         end
         ST_READ_EMIT: begin
            rsp_load_read = out_free;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = rsp_load_dist || rsp_load_read || (rsp_valid_ff && rsp_stall);

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         keep_ff      <= KEEP_RESET;
         inuse_ff     <= INUSE_RESET;
         counter_ff   <= '0;
         winner_ff    <= '0;
         best_ff      <= ONE_Q16;
         pend_ff      <= 1'b0;
         lo_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < INPUTS; i++) begin
            vec_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         counter_ff   <= counter_in;
         winner_ff    <= winner_in;
         best_ff      <= best_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_KEEP_FACTOR) begin
               keep_ff <= csr_data;
            end else begin
               inuse_ff <= csr_data[COUNT_BITS-1:0];
            end
         end
         if (vec_we) begin
            vec_ff[slot[INPUT_BITS-1:0]] <= req_element_value;
         end
         if (lo_we) begin
            lo_valid_ff[lo_addr_ff] <= 1'b1;
         end
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      nrn_ff     <= nrn_in;
      idx_ff     <= idx_in;
      pidx_ff    <= pidx_in;
      sum_ff     <= sum_in;
      lo_addr_ff <= lo_addr_in;
      tgt_ff     <= tgt_in;
   end

   // Result beat register.
   always_ff @(posedge clock) begin
      if (rsp_load_dist) begin
         rsp_kind_ff  <= KIND_DISTANCE;
         rsp_nrn_ff   <= nrn_ff;
         rsp_dist_ff  <= score.distance;
         rsp_close_ff <= score.closeness;
         rsp_read_ff  <= '0;
         if (nrn_ff == NEURON_BITS'(NEURONS - 1)) begin
            rsp_last_ff  <= 1'b1;
            rsp_win_ff   <= winner_in;
            rsp_wdist_ff <= best_in;
         end else begin
            rsp_last_ff  <= 1'b0;
            rsp_win_ff   <= '0;
            rsp_wdist_ff <= '0;
         end
      end else if (rsp_load_read) begin
         rsp_kind_ff  <= KIND_READ;
         rsp_nrn_ff   <= '0;
         rsp_dist_ff  <= '0;
         rsp_close_ff <= '0;
         rsp_win_ff   <= '0;
         rsp_wdist_ff <= '0;
         rsp_last_ff  <= 1'b0;
         rsp_read_ff  <= lo_valid_ff[lo_addr_ff] ? lo_rdata : '0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = rsp_kind_ff;
   assign rsp_neuron_index    = rsp_nrn_ff;
   assign rsp_distance        = rsp_dist_ff;
   assign rsp_closeness       = rsp_close_ff;
   assign rsp_winner_index    = rsp_win_ff;
   assign rsp_winner_distance = rsp_wdist_ff;
   assign rsp_last_result     = rsp_last_ff;
   assign rsp_read_value      = rsp_read_ff;

   // An emitted neuron result always lands in the output register.
   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free) |=> rsp_valid_ff)
      else $error("neuron result lost");

   // The winner is never worse than the last neuron's distance.
   a_winner_best: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_wdist_ff <= rsp_dist_ff))
      else $error("winner distance above a neuron distance");

   // The scan never reads past the elements in use.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (idx_ff <= n_cur))
      else $error("scan index beyond element count");

   // Reported distances stay within one.
   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_dist_ff <= ONE_Q16 && rsp_wdist_ff <= ONE_Q16))
      else $error("distance out of range");

endmodule

[rtl/core/cwl_ram.sv]
// ----------------------------------------------------------------------------
// cwl_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module cwl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/cwl_blend.sv]
// ----------------------------------------------------------------------------
// cwl_blend
// Two-stage blend of an old value towards a target: k*v + (1-k)*t, rounded.
// ----------------------------------------------------------------------------
module cwl_blend (
   input  logic                                  clock,
   input  logic [cwl_pkg::KEEP_BITS-1:0]         keep,
   input  logic signed [cwl_pkg::VALUE_BITS-1:0] old_value,
   input  logic signed [cwl_pkg::VALUE_BITS-1:0] target,
   output logic signed [cwl_pkg::VALUE_BITS-1:0] result
);
   import cwl_pkg::*;

   localparam int PROD_BITS = VALUE_BITS + KEEP_BITS + 2;

   logic signed [PROD_BITS-1:0]  keep_prod_ff;
   logic signed [PROD_BITS-1:0]  keep_prod_in;
   logic signed [VALUE_BITS-1:0] target_ff;
   logic [KEEP_BITS:0]           rest_ff;
   logic [KEEP_BITS:0]           rest_in;
   logic signed [PROD_BITS-1:0]  sum;

   // First stage: share of the old value.
   assign keep_prod_in = PROD_BITS'($signed({1'b0, keep}) * old_value);
   assign rest_in      = (KEEP_BITS + 1)'(2 ** KEEP_BITS) - {1'b0, keep};

   always_ff @(posedge clock) begin
      keep_prod_ff <= keep_prod_in;
      target_ff    <= target;
      rest_ff      <= rest_in;
   end

   // Second stage: add the target's share and round; the result is in range.
   assign sum = keep_prod_ff + PROD_BITS'($signed({1'b0, rest_ff}) * target_ff)
                + PROD_BITS'(2 ** (KEEP_BITS - 1));
   assign result = sum[KEEP_BITS +: VALUE_BITS];

endmodule

[rtl/core/cwl_score.sv]
// ----------------------------------------------------------------------------
// cwl_score
// Turns an L1 sum into a clamped distance by a bit-serial divider, then into a
// closeness value by one Q30 multiplication per distance bit.
// ----------------------------------------------------------------------------
module cwl_score (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [cwl_pkg::SUM_BITS-1:0]   sum,
   input  logic [cwl_pkg::COUNT_BITS-1:0] count,
   output cwl_pkg::score_type             result
);
   import cwl_pkg::*;

   localparam int STEP_BITS = $clog2(QUOT_BITS);

   score_state_type        state_ff;
   score_state_type        state_in;
   logic [QUOT_BITS-1:0]   quo_ff;
   logic [QUOT_BITS-1:0]   quo_in;
   logic [COUNT_BITS-1:0]  rem_ff;
   logic [COUNT_BITS-1:0]  rem_in;
   logic [STEP_BITS-1:0]   step_ff;
   logic [STEP_BITS-1:0]   step_in;
   logic [DIST_BITS-1:0]   dist_ff;
   logic [DIST_BITS-1:0]   dist_in;
   logic [30:0]            pow_ff;
   logic [30:0]            pow_in;
   logic [COUNT_BITS:0]    trial;
   logic                   trial_ok;
   logic [61:0]            pow_prod;
   logic [61:0]            pow_round;
   logic [31:0]            e_sum;
   logic [DIST_BITS-1:0]   e_val;
   logic [DIST_BITS-1:0]   close_full;

   // One quotient bit per cycle.
   assign trial    = {rem_ff, quo_ff[QUOT_BITS-1]};
   assign trial_ok = trial >= {1'b0, count};

   // One distance bit per cycle, most significant first.
   assign pow_prod  = 62'(pow_ff) * 62'(CLOSE_FACTORS[step_ff[$clog2(DIST_BITS)-1:0]]);
   assign pow_round = pow_prod + 62'(2 ** 29);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SC_IDLE: begin
            if (start) begin
               state_in = SC_DIV;
            end
         end
         SC_DIV: begin
            if (step_ff == STEP_BITS'(0)) begin
               state_in = SC_EXP;
            end
         end
         SC_EXP: begin
            if (step_ff == STEP_BITS'(0)) begin
               state_in = SC_DONE;
            end
         end
         SC_DONE: begin
            state_in = SC_IDLE;
         end
         default: begin
            state_in = SC_IDLE;
         end
      endcase
   end

   // Datapath.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      dist_in = dist_ff;
      pow_in  = pow_ff;
      case (state_ff)
         SC_IDLE: begin
            if (start) begin
               quo_in  = {sum, 1'b0};
               rem_in  = '0;
               step_in = STEP_BITS'(QUOT_BITS - 1);
            end
         end
         SC_DIV: begin
            quo_in = {quo_ff[QUOT_BITS-2:0], trial_ok};
            rem_in = trial_ok ? COUNT_BITS'(trial - {1'b0, count})
                              : trial[COUNT_BITS-1:0];
            if (step_ff == STEP_BITS'(0)) begin
               // Clamp to one and prepare the power walk.
               dist_in = ({quo_ff[QUOT_BITS-2:0], trial_ok} > QUOT_BITS'(ONE_Q16))
                         ? ONE_Q16
                         : quo_in[DIST_BITS-1:0];
               pow_in  = 31'(2 ** 30);
               step_in = STEP_BITS'(DIST_BITS - 1);
            end else begin
               step_in = step_ff - STEP_BITS'(1);
            end
         end
         SC_EXP: begin
            if (dist_ff[step_ff[$clog2(DIST_BITS)-1:0]]) begin
               pow_in = pow_round[60:30];
            end
            if (step_ff != STEP_BITS'(0)) begin
               step_in = step_ff - STEP_BITS'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
      end else begin
         state_ff <= state_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      dist_ff <= dist_in;
      pow_ff  <= pow_in;
   end

   // Closeness: one minus the rounded power, saturated.
   assign e_sum = {1'b0, pow_ff} + 32'(2 ** 13);
   assign e_val = e_sum[30:14];
   always_comb begin
      if (e_val >= ONE_Q16) begin
         close_full = '0;
      end else if (e_val == '0) begin
         close_full = DIST_BITS'(2 ** CLOSE_BITS - 1);
      end else begin
         close_full = ONE_Q16 - e_val;
      end
   end

   assign result.done      = (state_ff == SC_DONE);
   assign result.distance  = dist_ff;
   assign result.closeness = close_full[CLOSE_BITS-1:0];

   // A finished distance never exceeds one.
   a_dist_clamped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SC_EXP) |-> (dist_ff <= ONE_Q16))
      else $error("distance above one");

   // The power only shrinks from one.
   a_pow_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SC_EXP) |-> (pow_ff <= 31'(2 ** 30)))
      else $error("power above one");

   // Every start is followed by the division walk.
   a_start_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SC_IDLE && start) |=> (state_ff == SC_DIV))
      else $error("start not taken");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives sample, learn, blend, read and weight-load beats into the winner
// layer and compares every result beat against a predictor of its own.
// ----------------------------------------------------------------------------

// Predictor of the layer and store of expected result beats.
class winner_layer_scoreboard;
   typedef struct {
      logic                  kind;
      logic [3:0]            neuron;
      logic [16:0]           nrn_dist;
      logic [15:0]           close;
      logic [3:0]            win;
      logic [16:0]           win_dist;
      logic                  last;
      logic signed [15:0]    rd;
   } result_beat_type;

   int                weights [256];
   int                sample_vec [16];
   int                fill_count;
   int                learned [128];
   int                win_neuron;
   int                keep;
   int                in_use;
   result_beat_type   pending [$];
   int                errors;

   function new();
      foreach (weights[i]) weights[i] = 0;
      foreach (sample_vec[i]) sample_vec[i] = 0;
      foreach (learned[i]) learned[i] = 0;
      fill_count = 0;
      win_neuron = 0;
      keep = 58982;
      in_use = 16;
      errors = 0;
   endfunction

   function void write_reg(logic idx, logic [15:0] data);
      if (idx == cwl_pkg::CSR_KEEP_FACTOR) keep = int'(data);
      else in_use = int'(data[4:0]);
   endfunction

   // Integer square root by the classic bit-pair method.
   function longint unsigned root_of(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // One minus 100 to the power minus d, bit by bit.
   function logic [15:0] closeness_for(int d);
      longint unsigned r, p, e;
      r = 64'd10737418;
      p = 64'd1 << 30;
      for (int b = 16; b >= 0; b--) begin
         if (d[b]) p = (p * r + (64'd1 << 29)) >> 30;
         r = root_of(r << 30);
      end
      e = (p + (64'd1 << 13)) >> 14;
      if (e >= 65536) return 16'd0;
      e = 65536 - e;
      return (e > 65535) ? 16'hFFFF : e[15:0];
   endfunction

   function int mix(int old_v, int tgt);
      longint t;
      t = longint'(keep) * old_v + longint'(65536 - keep) * tgt + 32768;
      return int'(t >>> 16);
   endfunction

   function void note_input(logic [2:0] act, logic signed [15:0] val,
                            logic [3:0] nsel, logic [3:0] eidx,
                            logic [2:0] oidx, logic signed [15:0] tgt);
      int n, best, s, d;
      result_beat_type r;
      n = (in_use < 1) ? 1 : ((in_use > 16) ? 16 : in_use);
      case (act)
         cwl_pkg::ACT_SAMPLE: begin
            if (fill_count >= n) fill_count = 0;
            sample_vec[fill_count] = val;
            fill_count++;
            if (fill_count >= n) begin
               fill_count = 0;
               best = 65537;
               win_neuron = 0;
               for (int j = 0; j < 16; j++) begin
                  s = 0;
                  for (int i = 0; i < n; i++) begin
                     d = weights[j*16+i] - sample_vec[i];
                     s += (d < 0) ? -d : d;
                  end
                  d = (2 * s) / n;
                  if (d > 65536) d = 65536;
                  if (d < best) begin
                     best = d;
                     win_neuron = j;
                  end
                  r.kind     = cwl_pkg::KIND_DISTANCE;
                  r.neuron   = 4'(j);
                  r.nrn_dist = 17'(d);
                  r.close    = closeness_for(d);
                  r.win      = '0;
                  r.win_dist = '0;
                  r.last     = 1'b0;
                  r.rd       = '0;
                  if (j == 15) begin
                     r.win      = 4'(win_neuron);
                     r.win_dist = 17'(best);
                     r.last     = 1'b1;
                  end
                  pending = {pending, r};
               end
            end
         end
         cwl_pkg::ACT_LEARN:
            for (int i = 0; i < n; i++)
               weights[win_neuron*16+i] = mix(weights[win_neuron*16+i], sample_vec[i]);
         cwl_pkg::ACT_BLEND:
            learned[win_neuron*8+oidx] = mix(learned[win_neuron*8+oidx], tgt);
         cwl_pkg::ACT_READ: begin
            r.kind     = cwl_pkg::KIND_READ;
            r.neuron   = '0;
            r.nrn_dist = '0;
            r.close    = '0;
            r.win      = '0;
            r.win_dist = '0;
            r.last     = 1'b0;
            r.rd       = 16'(learned[win_neuron*8+oidx]);
            pending = {pending, r};
         end
         cwl_pkg::ACT_LOAD:
            weights[nsel*16+eidx] = val;
         default: ;
      endcase
   endfunction

   function void report(string field, longint e, longint a);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, e, a);
      errors++;
   endfunction

   function void check_result(result_beat_type got);
      result_beat_type exp_r;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result beat, kind %0d", $time, got.kind);
         errors++;
         return;
      end
      exp_r = pending.pop_front();
      if (got.kind !== exp_r.kind) report("kind", exp_r.kind, got.kind);
      if (got.neuron !== exp_r.neuron) report("neuron_index", exp_r.neuron, got.neuron);
      if (got.nrn_dist !== exp_r.nrn_dist)
         report("distance", exp_r.nrn_dist, got.nrn_dist);
      if (got.close !== exp_r.close) report("closeness", exp_r.close, got.close);
      if (got.win !== exp_r.win) report("winner_index", exp_r.win, got.win);
      if (got.win_dist !== exp_r.win_dist)
         report("winner_distance", exp_r.win_dist, got.win_dist);
      if (got.last !== exp_r.last) report("last_result", exp_r.last, got.last);
      if (got.rd !== exp_r.rd) report("read_value", exp_r.rd, got.rd);
   endfunction
endclass

module testbench;
   import cwl_pkg::*;

   // Spare action codes that the block ignores.
   localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
   localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;
   // Weight elements per neuron that are loaded, and so the largest count used.
   localparam int ELEMS_LOADED = 4;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [2:0]            req_action;
   logic signed [15:0]    req_element_value;
   logic [3:0]            req_neuron_select;
   logic [3:0]            req_element_index;
   logic [2:0]            req_output_index;
   logic signed [15:0]    req_target_value;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_result_kind;
   logic [3:0]            rsp_neuron_index;
   logic [16:0]           rsp_distance;
   logic [15:0]           rsp_closeness;
   logic [3:0]            rsp_winner_index;
   logic [16:0]           rsp_winner_distance;
   logic                  rsp_last_result;
   logic signed [15:0]    rsp_read_value;
   logic                  csr_valid;
   logic                  csr_ready;
   logic                  csr_index;
   logic [15:0]           csr_data;

   winner_layer_scoreboard layer_model;
   int  hold_off_cycles;
   int  beats_in_burst;

   competitive_layer_winner_learn_top u_top (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("CHECK FAILED");
      $finish;
   end

   // Receiver: stall pattern of its own, plus a long hold-off on request.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 3) == 0) && ($time % 4000 > 1500);
         end
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         layer_model.check_result('{rsp_result_kind, rsp_neuron_index, rsp_distance,
            rsp_closeness, rsp_winner_index, rsp_winner_distance, rsp_last_result,
            rsp_read_value});
   end

   // Offer one beat, hold it until accepted, then perhaps idle for a gap.
   task automatic send_beat(logic [2:0] act, logic signed [15:0] val,
                            logic [3:0] nsel, logic [3:0] eidx,
                            logic [2:0] oidx, logic signed [15:0] tgt);
      req_valid         <= 1'b1;
      req_action        <= act;
      req_element_value <= val;
      req_neuron_select <= nsel;
      req_element_index <= eidx;
      req_output_index  <= oidx;
      req_target_value  <= tgt;
      do @(posedge clock); while (req_stall);
      layer_model.note_input(act, val, nsel, eidx, oidx, tgt);
      if (beats_in_burst > 0) begin
         beats_in_burst--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         beats_in_burst = $urandom_range(0, 8);
      end
   endtask

   task automatic load_weight(int nrn, int el, logic signed [15:0] val);
      send_beat(ACT_LOAD, val, 4'(nrn), 4'(el), 3'($urandom), 16'($urandom));
   endtask

   task automatic send_sample(int count, bit extreme);
      logic signed [15:0] v;
      for (int i = 0; i < count; i++) begin
         v = extreme ? (($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000)
                     : 16'($urandom_range(0, 32767) - 16384);
         send_beat(ACT_SAMPLE, v, 4'($urandom), 4'($urandom), 3'($urandom),
                   16'($urandom));
      end
   endtask

   // Let the block drain, then wait out any trailing work.
   task automatic drain();
      req_valid <= 1'b0;
      while (layer_model.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      layer_model.write_reg(idx, data);
      @(posedge clock);
   endtask

   initial begin
      int act, n;
      logic signed [15:0] v;
      layer_model       = new();
      hold_off_cycles   = 0;
      beats_in_burst    = 0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_action        = ACT_SAMPLE;
      req_element_value = '0;
      req_neuron_select = '0;
      req_element_index = '0;
      req_output_index  = '0;
      req_target_value  = '0;
      csr_valid         = 1'b0;
      csr_index         = CSR_KEEP_FACTOR;
      csr_data          = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Only the leading weight elements are loaded, so the count stays within them.
      write_csr(CSR_INPUTS_IN_USE, 16'(ELEMS_LOADED));

      // Directed: loaded weights include the extremes, so no read is undefined.
      for (int j = 0; j < 16; j++)
         for (int i = 0; i < ELEMS_LOADED; i++)
            if (j == 0) load_weight(j, i, 16'sh7FFF);
            else if (j == 1) load_weight(j, i, 16'sh8000);
            else load_weight(j, i, 16'($urandom_range(0, 32767) - 16384));
      send_beat(ACT_LEARN, '0, '0, '0, '0, '0);      // learn before any sample
      send_beat(ACT_READ, '0, '0, '0, 3'd7, '0);
      send_beat(ACT_BLEND, '0, '0, '0, 3'd7, 16'sh7FFF);
      send_beat(ACT_BLEND, '0, '0, '0, 3'd0, 16'sh8000);
      send_beat(ACT_READ, '0, '0, '0, 3'd7, '0);
      send_beat(ACT_SPARE_FIRST, 16'sh7FFF, 4'hF, 4'hF, 3'h7, 16'sh8000);
      send_beat(ACT_SPARE_LAST, '0, '0, '0, '0, '0);
      send_sample(ELEMS_LOADED, 1);
      send_sample(ELEMS_LOADED - 1, 0);               // partial sample at learn
      send_beat(ACT_LEARN, '0, '0, '0, '0, '0);
      drain();

      // Lower the element count below the counter, and use extreme keep factors.
      write_csr(CSR_INPUTS_IN_USE, 16'd1);
      write_csr(CSR_KEEP_FACTOR, 16'd0);
      send_sample(1, 1);
      send_beat(ACT_LEARN, '0, '0, '0, '0, '0);
      send_beat(ACT_BLEND, '0, '0, '0, 3'd3, 16'sh8000);
      send_beat(ACT_READ, '0, '0, '0, 3'd3, '0);
      drain();
      write_csr(CSR_KEEP_FACTOR, 16'hFFFF);
      write_csr(CSR_INPUTS_IN_USE, 16'd0);            // clamps to one element
      send_sample(1, 0);
      send_beat(ACT_LEARN, '0, '0, '0, '0, '0);
      drain();

      // Random phases at several settings; long receiver hold-off in the first.
      for (int phase = 0; phase < 4; phase++) begin
         n = (phase == 3) ? ELEMS_LOADED : $urandom_range(1, ELEMS_LOADED);
         write_csr(CSR_INPUTS_IN_USE, 16'(n));
         write_csr(CSR_KEEP_FACTOR, 16'($urandom));
         if (phase == 0) begin
            hold_off_cycles = 600;
            send_sample(n, 0);
         end
         for (int k = 0; k < 10; k++) begin
            act = $urandom_range(0, 9);
            if (act < 4) begin
               send_sample(n, 0);
            end else if (act == 4) begin
               send_beat(ACT_LEARN, 16'($urandom), 4'($urandom), 4'($urandom),
                         3'($urandom), 16'($urandom));
            end else if (act == 5) begin
               send_beat(ACT_BLEND, 16'($urandom), 4'($urandom), 4'($urandom),
                         3'($urandom), 16'($urandom));
            end else if (act == 6) begin
               send_beat(ACT_READ, 16'($urandom), 4'($urandom), 4'($urandom),
                         3'($urandom), 16'($urandom));
            end else if (act == 7) begin
               v = 16'($urandom);
               send_beat(ACT_LOAD, v, 4'($urandom), 4'($urandom), 3'($urandom),
                         16'($urandom));
            end else begin
               send_beat(3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST)),
                         16'($urandom), 4'($urandom), 4'($urandom),
                         3'($urandom), 16'($urandom));
            end
         end
         // Pause until everything expected has come.
         drain();
      end

      if (layer_model.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
